/* rtl/core/prb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_pkg: shared definitions for the picture reorder buffer
// Field widths, codes, the scan token and the per-cell control group.
// ----------------------------------------------------------------------------
package prb_pkg;

	// Default number of cells in the reorder chain.
	localparam int CAPACITY_DEF = 8;

	// Field widths.
	localparam int ID_W    = 8;
	localparam int TS_W    = 64;
	localparam int ORD_W   = 32;
	localparam int DEPTH_W = 3;

	// Reset value of the reorder depth register.
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd5;

	// Item kinds carried in the mode bit.
	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// Register index decoded from the word address.
	localparam logic REG_DEPTH = 1'b0;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Search token that travels down the chain, one cell per cycle.
	typedef struct packed {
		logic                    act;
		logic                    have;
		logic                    stop;
		logic signed [ORD_W-1:0] key;
	} tok_t;

	// Storage control broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

/* rtl/core/prb_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_cell: one entry of the reorder chain
// Holds one picture, takes part in the search as the token passes and
// closes up the gap by loading its younger neighbor.
// ----------------------------------------------------------------------------
module prb_cell #(
	parameter int CAPACITY = prb_pkg::CAPACITY_DEF,
	parameter int INDEX    = 0,
	localparam int IW      = $clog2(CAPACITY),
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  prb_pkg::cell_ctl_t               ctl,
	input  logic [CW-1:0]                    count,
	input  logic [IW-1:0]                    pick,
	input  logic [prb_pkg::ID_W-1:0]         ins_buf,
	input  logic [prb_pkg::TS_W-1:0]         ins_stamp,
	input  logic signed [prb_pkg::ORD_W-1:0] ins_order,
	input  logic [prb_pkg::ID_W-1:0]         nxt_buf,
	input  logic [prb_pkg::TS_W-1:0]         nxt_stamp,
	input  logic signed [prb_pkg::ORD_W-1:0] nxt_order,
	input  prb_pkg::tok_t                    tok_in,
	input  logic [IW-1:0]                    idx_in,
	output prb_pkg::tok_t                    tok_out,
	output logic [IW-1:0]                    idx_out,
	output logic [prb_pkg::ID_W-1:0]         ent_buf,
	output logic [prb_pkg::TS_W-1:0]         ent_stamp,
	output logic signed [prb_pkg::ORD_W-1:0] ent_order
);

	logic [prb_pkg::ID_W-1:0]         buf_q;
	logic [prb_pkg::TS_W-1:0]         stamp_q;
	logic signed [prb_pkg::ORD_W-1:0] order_q;
	prb_pkg::tok_t                    tok_q;
	prb_pkg::tok_t                    tok_nxt;
	logic [IW-1:0]                    idx_q;
	logic [IW-1:0]                    idx_nxt;
	logic                             in_range;

	// Entry storage: write at the fill position, or shift toward the head.
	always_ff @(posedge clk) begin
		if (ctl.ins && count == CW'(INDEX)) begin
			buf_q   <= ins_buf;
			stamp_q <= ins_stamp;
			order_q <= ins_order;
		end else if (ctl.shift && pick <= IW'(INDEX)) begin
			buf_q   <= nxt_buf;
			stamp_q <= nxt_stamp;
			order_q <= nxt_order;
		end
	end

	// Search step: keep the least key, stop at a later zero key.
	always_comb begin
		in_range = CW'(INDEX) < count;
		tok_nxt  = tok_in;
		idx_nxt  = idx_in;
		if (tok_in.act && in_range && !tok_in.stop) begin
			if (tok_in.have && order_q == '0) begin
				tok_nxt.stop = 1'b1;
			end else if (!tok_in.have || order_q < tok_in.key) begin
				tok_nxt.have = 1'b1;
				tok_nxt.key  = order_q;
				idx_nxt      = IW'(INDEX);
			end
		end
	end

	// Token register handing the search on to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			idx_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			idx_q <= idx_nxt;
		end
	end

	assign tok_out   = tok_q;
	assign idx_out   = idx_q;
	assign ent_buf   = buf_q;
	assign ent_stamp = stamp_q;
	assign ent_order = order_q;

endmodule

/* rtl/core/picture_reorder_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picture_reorder_buffer_unit: display reorder store for decoded pictures
// Holds decoded pictures in arrival order and releases them by order count.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_ stream. An add stores one picture at the
//   tail of a chain of cells; once more pictures are held than the reorder
//   depth allows, one picture is emitted on the m_ stream. A drain always
//   emits one result, with found low when nothing is held.
//   An add that gives no result skips the search. For an item that emits,
//   the search token walks the chain one cell per cycle; then, once the
//   output register is free, the winner is loaded into it and the gap is
//   closed up. One item is worked on at a time. The result sits in an
//   output register, so the next item is accepted while it waits;
//   a stalled receiver only holds back the following result. Reset
//   empties the store and sets the reorder depth to 5. The depth register
//   sits at address 0 of the APB port and should only be written while
//   the block is idle.
// ----------------------------------------------------------------------------
module picture_reorder_buffer_unit #(
	parameter int CAPACITY = prb_pkg::CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// buffer_id[7:0], time_stamp[71:8], top_order[103:72], bottom_order[135:104]
	input  logic [135:0] s_tdata,
	// mode[0], is_field_picture[1], is_bottom_field[2]
	input  logic [2:0]   s_tuser,
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_buffer_id[7:0], out_time_stamp[71:8]
	output logic [71:0]  m_tdata,
	// found[0]
	output logic [0:0]   m_tuser,
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// Input field split.
	logic                             in_mode;
	logic [prb_pkg::ID_W-1:0]         in_buf;
	logic [prb_pkg::TS_W-1:0]         in_stamp;
	logic signed [prb_pkg::ORD_W-1:0] in_top;
	logic signed [prb_pkg::ORD_W-1:0] in_bot;
	logic                             in_field;
	logic                             in_bfield;
	logic signed [prb_pkg::ORD_W-1:0] in_key;
	logic                             in_skip;

	// Control state.
	prb_pkg::state_t                  state_q;
	prb_pkg::state_t                  state_nxt;
	logic [CW-1:0]                    count_q;
	logic [prb_pkg::DEPTH_W-1:0]      depth_q;
	logic [7:0]                       depth_eff;
	logic                             start;
	logic                             start_q;
	logic                             have_q;
	logic [IW-1:0]                    pick_q;
	logic                             accept;
	logic                             out_free;
	prb_pkg::cell_ctl_t               ctl;
	logic                             cfg_wr;

	// Output register.
	logic                             m_tvalid_q;
	logic                             found_q;
	logic [prb_pkg::ID_W-1:0]         obuf_q;
	logic [prb_pkg::TS_W-1:0]         ostamp_q;

	// Chain wiring.
	prb_pkg::tok_t                    tok [CAPACITY+1];
	logic [IW-1:0]                    tidx [CAPACITY+1];
	logic [prb_pkg::ID_W-1:0]         cell_buf [CAPACITY];
	logic [prb_pkg::TS_W-1:0]         cell_stamp [CAPACITY];
	logic signed [prb_pkg::ORD_W-1:0] cell_order [CAPACITY];
	logic [CAPACITY:0]                tok_act;

	assign in_buf    = s_tdata[7:0];
	assign in_stamp  = s_tdata[71:8];
	assign in_top    = s_tdata[103:72];
	assign in_bot    = s_tdata[135:104];
	assign in_mode   = s_tuser[0];
	assign in_field  = s_tuser[1];
	assign in_bfield = s_tuser[2];

	// Key is the smaller count; the first field of a pair is dropped.
	assign in_key  = (in_top < in_bot) ? in_top : in_bot;
	assign in_skip = in_field && (in_bfield != (in_top < in_bot));

	// Depth in use never exceeds the store size minus one.
	assign depth_eff = (8'(depth_q) > 8'(CAPACITY - 1)) ? 8'(CAPACITY - 1) : 8'(depth_q);

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && paddr[2] == prb_pkg::REG_DEPTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= prb_pkg::DEPTH_RESET;
		end else if (cfg_wr) begin
			depth_q <= pwdata[prb_pkg::DEPTH_W-1:0];
		end
	end

	assign prdata = (paddr[2] == prb_pkg::REG_DEPTH) ? 32'(depth_q) : '0;

	// Handshakes.
	assign s_tready = (state_q == prb_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer next state and cell control.
	always_comb begin
		state_nxt = state_q;
		start     = 1'b0;
		ctl       = '0;
		unique case (state_q)
			prb_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_mode == prb_pkg::MODE_DRAIN) begin
						start     = 1'b1;
						state_nxt = prb_pkg::ST_SCAN;
					end else if (!in_skip) begin
						ctl.ins = 1'b1;
						if (8'(count_q) >= depth_eff) begin
							start     = 1'b1;
							state_nxt = prb_pkg::ST_SCAN;
						end
					end
				end
			end
			prb_pkg::ST_SCAN: begin
				if (tok[CAPACITY].act) begin
					state_nxt = prb_pkg::ST_DONE;
				end
			end
			prb_pkg::ST_DONE: begin
				if (out_free) begin
					ctl.shift = have_q;
					state_nxt = prb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = prb_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer registers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prb_pkg::ST_IDLE;
			count_q <= '0;
			start_q <= 1'b0;
			have_q  <= 1'b0;
			pick_q  <= '0;
		end else begin
			state_q <= state_nxt;
			start_q <= start;
			if (ctl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.shift) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == prb_pkg::ST_SCAN && tok[CAPACITY].act) begin
				have_q <= tok[CAPACITY].have;
				pick_q <= tidx[CAPACITY];
			end
		end
	end

	// Search token enters the head of the chain.
	assign tok[0]  = '{act: start_q, have: 1'b0, stop: 1'b0, key: '0};
	assign tidx[0] = '0;

	// Chain of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [prb_pkg::ID_W-1:0]         nb_buf;
		logic [prb_pkg::TS_W-1:0]         nb_stamp;
		logic signed [prb_pkg::ORD_W-1:0] nb_order;

		if (i == CAPACITY - 1) begin : g_tail
			assign nb_buf   = cell_buf[i];
			assign nb_stamp = cell_stamp[i];
			assign nb_order = cell_order[i];
		end else begin : g_body
			assign nb_buf   = cell_buf[i+1];
			assign nb_stamp = cell_stamp[i+1];
			assign nb_order = cell_order[i+1];
		end

		prb_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (count_q),
			.pick      (pick_q),
			.ins_buf   (in_buf),
			.ins_stamp (in_stamp),
			.ins_order (in_key),
			.nxt_buf   (nb_buf),
			.nxt_stamp (nb_stamp),
			.nxt_order (nb_order),
			.tok_in    (tok[i]),
			.idx_in    (tidx[i]),
			.tok_out   (tok[i+1]),
			.idx_out   (tidx[i+1]),
			.ent_buf   (cell_buf[i]),
			.ent_stamp (cell_stamp[i]),
			.ent_order (cell_order[i])
		);
	end

	for (genvar j = 0; j <= CAPACITY; j++) begin : g_act
		assign tok_act[j] = tok[j].act;
	end

	// Output register: loaded with the winner, or zeros when nothing is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == prb_pkg::ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == prb_pkg::ST_DONE && out_free) begin
			found_q  <= have_q;
			obuf_q   <= have_q ? cell_buf[pick_q] : '0;
			ostamp_q <= have_q ? cell_stamp[pick_q] : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {ostamp_q, obuf_q};
	assign m_tuser  = found_q;

	// The fill count never passes the number of cells; it reaches that
	// number only while an add that forces one picture out is searched.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("fill count exceeds the store size");

	// Only one search is ever in flight along the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_act) <= 1)
		else $error("more than one search token in the chain");

	// A finished search arrives only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		tok[CAPACITY].act |-> state_q == prb_pkg::ST_SCAN)
		else $error("search finished outside the scan state");

	// A not-found result carries an all-zero payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("not-found result with nonzero payload");

endmodule
